// ===== rtl/core/fnvrim_pkg.sv =====
// fnvrim_pkg: constants, types and the hash step for the region integrity monitor
// self-contained, no dependencies
package fnvrim_pkg;

  localparam int unsigned HashW       = 64;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned RegionW     = 2;
  localparam int unsigned RegionCount = 3;

  localparam logic [HashW-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;
  localparam logic [HashW-1:0] FnvPrime = 64'h0000_0100_0000_01b3;

  typedef enum logic {
    OP_SNAPSHOT = 1'b0,
    OP_CHECK    = 1'b1
  } op_e;

  typedef logic [HashW-1:0] hash_t;

  // one fnv-1a round: xor the byte in, multiply by the prime mod 2^64
  // prime = 2^40 + 2^8 + 0xb3, 0xb3 = bits 7, 5, 4, 1, 0
  function automatic hash_t fnv_step(input hash_t h, input logic [ByteW-1:0] b);
    hash_t x;
    x = h ^ {{(HashW-ByteW){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== rtl/core/fnv1a_region_integrity_monitor_unit.sv =====
// fnv1a_region_integrity_monitor_unit: fnv-1a 64 hashing of protected regions
// with per-region reference storage and tamper check; depends on fnvrim_pkg
//
// usage
//   input channel: one request per byte (data_byte_i, last_byte_i, region_i,
//   operation_i), accepted when in_valid_i is high and in_stall_o is low.
//   every byte is folded into one shared accumulator; the byte marked last
//   closes the region, reloads the accumulator with the offset basis and
//   produces one result, taking the region and operation that came with it.
//   output channel: region_hash_o, tampered_o, region_done_o, taken when
//   out_valid_o is high and out_stall_i is low. bytes not marked last give
//   no result.
//   snapshot stores the hash as the region's reference; check compares and
//   flags a mismatch. regions at or above REGION_COUNT store nothing and
//   never flag.
// timing
//   one byte per cycle sustained while in_stall_o is low. a last byte is
//   loaded into the input register, then the hash register (the sparse
//   multiply by the prime is a handful of shifted adds), then the result
//   register (compare)
// reset and stall
//   reset loads the offset basis, clears all references to zero and empties
//   the pipeline. a stalled receiver holds the result register; bytes not
//   marked last keep flowing until a last byte finds the hash stage full.
module fnv1a_region_integrity_monitor_unit #(
  parameter int unsigned REGION_COUNT = fnvrim_pkg::RegionCount
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fnvrim_pkg::ByteW-1:0]    data_byte_i,
  input  logic                            last_byte_i,
  input  logic [fnvrim_pkg::RegionW-1:0]  region_i,
  input  logic                            operation_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fnvrim_pkg::HashW-1:0]    region_hash_o,
  output logic                            tampered_o,
  output logic [fnvrim_pkg::RegionW-1:0]  region_done_o
);
  import fnvrim_pkg::*;

  // index width of the reference store, at least one bit
  localparam int unsigned IdxW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned CmpW = 5;

  // stage 1: input register
  logic               s1_valid_q;
  logic [ByteW-1:0]   s1_byte_q;
  logic               s1_last_q;
  logic [RegionW-1:0] s1_region_q;
  op_e                s1_op_q;

  // running accumulator
  hash_t running_q, running_d;
  hash_t step_hash;

  // stage 2: hash register, holds only region-closing requests
  logic               s2_valid_q;
  hash_t              s2_hash_q;
  logic [RegionW-1:0] s2_region_q;
  op_e                s2_op_q;

  // stage 3: result register
  logic               out_valid_q;
  hash_t              out_hash_q;
  logic               out_tamp_q;
  logic [RegionW-1:0] out_region_q;

  // reference store
  hash_t ref_q [REGION_COUNT];

  logic out_ready, s2_ready, s2_adv, s1_move, s1_ready, in_accept;
  logic s2_in_range;
  logic [IdxW+RegionW-1:0] s2_idx_ext;
  logic [IdxW-1:0]         s2_idx;
  hash_t                   ref_rd;
  logic                    tamp_d;

  // handshake chain: non-closing bytes never need stage 2
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s2_adv    = s2_valid_q && out_ready;
  assign s1_move   = s1_valid_q && (!s1_last_q || s2_ready);
  assign s1_ready  = !s1_valid_q || s1_move;
  assign in_accept = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  // hash round on the byte leaving stage 1
  assign step_hash = fnv_step(running_q, s1_byte_q);
  always_comb begin
    running_d = running_q;
    if (s1_move) begin
      running_d = s1_last_q ? FnvBasis : step_hash;
    end
  end

  // reference lookup and compare for the closing request in stage 2
  assign s2_in_range = {{(CmpW-RegionW){1'b0}}, s2_region_q} < CmpW'(REGION_COUNT);
  assign s2_idx_ext  = {{IdxW{1'b0}}, s2_region_q};
  assign s2_idx      = s2_idx_ext[IdxW-1:0];
  assign ref_rd      = ref_q[s2_idx];
  assign tamp_d      = s2_in_range && (s2_op_q == OP_CHECK) && (s2_hash_q != ref_rd);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= FnvBasis;
    end else begin
      running_q <= running_d;
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_move && s1_last_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // reference store, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < REGION_COUNT; k++) begin
        ref_q[k] <= '0;
      end
    end else if (s2_adv && s2_in_range && (s2_op_q == OP_SNAPSHOT)) begin
      ref_q[s2_idx] <= s2_hash_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q   <= data_byte_i;
      s1_last_q   <= last_byte_i;
      s1_region_q <= region_i;
      s1_op_q     <= op_e'(operation_i);
    end
    if (s2_ready && s1_move && s1_last_q) begin
      s2_hash_q   <= step_hash;
      s2_region_q <= s1_region_q;
      s2_op_q     <= s1_op_q;
    end
    if (s2_adv) begin
      out_hash_q   <= s2_hash_q;
      out_tamp_q   <= tamp_d;
      out_region_q <= s2_region_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign region_hash_o = out_hash_q;
  assign tampered_o    = out_tamp_q;
  assign region_done_o = out_region_q;

`ifndef NO_ASSERTIONS
  // a closing byte always returns the accumulator to the offset basis
  a_basis_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_last_q |=> running_q == FnvBasis)
    else $error("accumulator not reloaded after last byte");

  // a region outside the reference store never flags tampering
  a_tamper_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_tamp_q |->
      {{(CmpW-RegionW){1'b0}}, out_region_q} < CmpW'(REGION_COUNT))
    else $error("tamper flag on out-of-range region");

  // input stalls only when stage 1 holds a blocked closing byte
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && s2_valid_q && out_valid_q)
    else $error("input stalled without a full pipeline");
`endif

endmodule
